### hdl/qpn_pkg.sv
// Package for the quaternion product and normalize unit.
// Holds the request codes, the default component width and the queue depth.
// No dependencies.
package qpn_pkg;

    localparam int COMP_WIDTH  = 16;
    localparam int QUEUE_DEPTH = 4;
    localparam int TOP_BIT     = 29;

    localparam logic [1:0] REQ_PRODUCT   = 2'd0;
    localparam logic [1:0] REQ_NORM      = 2'd1;
    localparam logic [1:0] REQ_NORM_CONJ = 2'd2;
    localparam logic [1:0] REQ_CONJ      = 2'd3;

    typedef struct packed {
        logic s1_valid;
        logic s2_valid;
    } front_stat_t;

endpackage

### hdl/qpn_front.sv
// Front end of the quaternion unit: multiplies, classifies and prepares vectors.
// Depends on qpn_pkg.
module qpn_front #(
    parameter int COMP_WIDTH = qpn_pkg::COMP_WIDTH
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 accept,
    input  logic [1:0]                           req_type,
    input  logic signed [COMP_WIDTH-1:0]         a_x,
    input  logic signed [COMP_WIDTH-1:0]         a_y,
    input  logic signed [COMP_WIDTH-1:0]         a_z,
    input  logic signed [COMP_WIDTH-1:0]         a_w,
    input  logic signed [COMP_WIDTH-1:0]         b_x,
    input  logic signed [COMP_WIDTH-1:0]         b_y,
    input  logic signed [COMP_WIDTH-1:0]         b_z,
    input  logic signed [COMP_WIDTH-1:0]         b_w,
    output logic                                 push,
    output logic [12*COMP_WIDTH+8:0]             push_data,
    output qpn_pkg::front_stat_t                 stat
);

    localparam int W  = COMP_WIDTH;
    localparam int PW = 2 * W;
    localparam int VW = 2 * W + 2;
    localparam int PS = (2 * W > 60) ? (2 * W - 60) : 0;

    logic signed [W-1:0]  a_in [4];
    logic signed [W-1:0]  b_in [4];
    logic signed [W-1:0]  raw_in [4];
    logic signed [PW-1:0] prod [16];

    logic                 s1_valid_reg;
    logic [1:0]           s1_op_reg;
    logic signed [W-1:0]  s1_a_reg [4];
    logic signed [W-1:0]  s1_raw_reg [4];
    logic signed [PW-1:0] s1_p_reg [16];

    logic signed [VW-1:0] t [16];
    logic signed [VW-1:0] v [4];

    logic                 s2_valid_reg;
    logic                 s2_rawflag_reg;
    logic signed [W-1:0]  s2_raw_reg [4];
    logic signed [VW-1:0] s2_v_reg [4];

    always_comb
    begin
        a_in[0] = a_x;
        a_in[1] = a_y;
        a_in[2] = a_z;
        a_in[3] = a_w;
        b_in[0] = b_x;
        b_in[1] = b_y;
        b_in[2] = b_z;
        b_in[3] = b_w;
        for (int i = 0; i < 4; i++)
        begin
            for (int j = 0; j < 4; j++)
            begin
                prod[i*4+j] = a_in[i] * b_in[j];
            end
        end
        for (int i = 0; i < 3; i++)
        begin
            if (a_in[i] == {1'b1, {(W-1){1'b0}}})
            begin
                raw_in[i] = {1'b0, {(W-1){1'b1}}};
            end
            else
            begin
                raw_in[i] = -a_in[i];
            end
        end
        raw_in[3] = a_in[3];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_op_reg <= req_type;
        s1_a_reg  <= a_in;
        s1_raw_reg <= raw_in;
        s1_p_reg  <= prod;
    end

    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            t[i] = VW'(s1_p_reg[i]) >>> PS;
        end
        for (int i = 0; i < 4; i++)
        begin
            v[i] = VW'(s1_a_reg[i]);
        end
        unique case (s1_op_reg)
            qpn_pkg::REQ_PRODUCT:
            begin
                v[0] = t[6] - t[9] + t[3] + t[12];
                v[1] = t[8] - t[2] + t[7] + t[13];
                v[2] = t[1] - t[4] + t[11] + t[14];
                v[3] = t[15] - t[0] - t[5] - t[10];
            end
            qpn_pkg::REQ_NORM_CONJ:
            begin
                v[0] = -VW'(s1_a_reg[0]);
                v[1] = -VW'(s1_a_reg[1]);
                v[2] = -VW'(s1_a_reg[2]);
                v[3] = VW'(s1_a_reg[3]);
            end
            qpn_pkg::REQ_NORM, qpn_pkg::REQ_CONJ:
            begin
                v[3] = VW'(s1_a_reg[3]);
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        s2_rawflag_reg <= (s1_op_reg == qpn_pkg::REQ_CONJ);
        s2_raw_reg     <= s1_raw_reg;
        s2_v_reg       <= v;
    end

    assign push = s2_valid_reg;
    assign push_data = {s2_rawflag_reg,
                        s2_raw_reg[3], s2_raw_reg[2], s2_raw_reg[1], s2_raw_reg[0],
                        s2_v_reg[3], s2_v_reg[2], s2_v_reg[1], s2_v_reg[0]};
    assign stat.s1_valid = s1_valid_reg;
    assign stat.s2_valid = s2_valid_reg;

endmodule

### hdl/qpn_queue.sv
// Short queue between the front end and the normalize pipeline.
// Depends on qpn_pkg for its default depth.
module qpn_queue #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = qpn_pkg::QUEUE_DEPTH
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic [DATA_W-1:0]          push_data,
    output logic [$clog2(DEPTH+1)-1:0] level,
    output logic                       out_valid,
    output logic [DATA_W-1:0]          out_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [AW-1:0]     wr_ptr_reg;
    logic [AW-1:0]     rd_ptr_reg;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    logic              pop;
    logic              out_valid_reg;
    logic [DATA_W-1:0] out_data_reg;

    assign pop = (count_reg != '0);

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= pop;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
        if (pop)
        begin
            out_data_reg <= mem[rd_ptr_reg];
        end
    end

    assign level     = count_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // A write into a full queue would drop a transaction.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg != CW'(DEPTH)) || pop)
        else $error("queue overflow");

    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue level out of range");

endmodule

### hdl/qpn_back.sv
// Normalize pipeline: magnitude, scaling, sum of squares, square root and division.
// Depends on qpn_pkg; fed by qpn_queue.
module qpn_back #(
    parameter int COMP_WIDTH = qpn_pkg::COMP_WIDTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [12*COMP_WIDTH+8:0]      in_data,
    output logic                          done,
    output logic signed [COMP_WIDTH-1:0]  res_x,
    output logic signed [COMP_WIDTH-1:0]  res_y,
    output logic signed [COMP_WIDTH-1:0]  res_z,
    output logic signed [COMP_WIDTH-1:0]  res_w,
    output logic                          zero_length
);

    localparam int W        = COMP_WIDTH;
    localparam int F        = W - 2;
    localparam int VW       = 2 * W + 2;
    localparam int MW       = VW - 1;
    localparam int TW       = $clog2(MW);
    localparam int NW       = qpn_pkg::TOP_BIT + 1;
    localparam int SQW      = 2 * NW + 2;
    localparam int LW       = NW + 1;
    localparam int DW       = F + LW + 1;
    localparam int QW       = F + 1;
    localparam int RAW_W    = 4 * W;
    localparam int SIDE_W   = RAW_W + 6;
    localparam int SQ_STEPS = NW + 1;

    // Side bundle: raw flag, zero flag, four sign bits, raw conjugate result.
    logic signed [VW-1:0] vin [4];
    logic [MW-1:0]        mag [4];
    logic [3:0]           neg;
    logic [MW-1:0]        all_in;

    logic                 a_valid_reg;
    logic [SIDE_W-1:0]    a_side_reg;
    logic [MW-1:0]        a_m_reg [4];
    logic [MW-1:0]        a_all_reg;

    logic [TW-1:0]        top;
    logic                 t_valid_reg;
    logic [SIDE_W-1:0]    t_side_reg;
    logic [MW-1:0]        t_m_reg [4];
    logic [TW-1:0]        t_top_reg;

    logic [NW-1:0]        shifted [4];
    logic                 h_valid_reg;
    logic [SIDE_W-1:0]    h_side_reg;
    logic [NW-1:0]        h_m_reg [4];

    logic                 q_valid_reg;
    logic [SIDE_W-1:0]    q_side_reg;
    logic [NW-1:0]        q_m_reg [4];
    logic [2*NW-1:0]      q_sq_reg [4];

    logic [SQ_STEPS:0]    sq_valid_reg;
    logic [SIDE_W-1:0]    sq_side_reg [SQ_STEPS+1];
    logic [NW-1:0]        sq_m_reg [SQ_STEPS+1][4];
    logic [SQW-1:0]       sq_n_reg [SQ_STEPS+1];
    logic [SQW-1:0]       sq_r_reg [SQ_STEPS+1];

    logic [LW-1:0]        len;
    logic [QW:0]          dv_valid_reg;
    logic [SIDE_W-1:0]    dv_side_reg [QW+1];
    logic [LW-1:0]        dv_len_reg [QW+1];
    logic [DW-1:0]        dv_rem_reg [QW+1][4];
    logic [QW-1:0]        dv_q_reg [QW+1][4];

    logic                 out_valid_reg;
    logic signed [W-1:0]  out_res_reg [4];
    logic                 out_zero_reg;
    logic signed [W-1:0]  res_next [4];
    logic                 zero_next;
    logic [SIDE_W-1:0]    fin_side;

    always_comb
    begin
        all_in = '0;
        for (int i = 0; i < 4; i++)
        begin
            vin[i] = signed'(in_data[i*VW +: VW]);
            neg[i] = vin[i][VW-1];
            mag[i] = neg[i] ? MW'(-vin[i]) : MW'(vin[i]);
            all_in = all_in | mag[i];
        end
    end

    always_comb
    begin
        top = '0;
        for (int i = 0; i < MW; i++)
        begin
            if (a_all_reg[i])
            begin
                top = TW'(i);
            end
        end
    end

    always_comb
    begin
        logic [MW+NW-1:0] ext;
        for (int i = 0; i < 4; i++)
        begin
            ext = (MW+NW)'(t_m_reg[i]);
            if (t_top_reg > TW'(qpn_pkg::TOP_BIT))
            begin
                ext = ext >> (t_top_reg - TW'(qpn_pkg::TOP_BIT));
            end
            else
            begin
                ext = ext << (TW'(qpn_pkg::TOP_BIT) - t_top_reg);
            end
            shifted[i] = ext[NW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg     <= 1'b0;
            t_valid_reg     <= 1'b0;
            h_valid_reg     <= 1'b0;
            q_valid_reg     <= 1'b0;
            sq_valid_reg[0] <= 1'b0;
        end
        else
        begin
            a_valid_reg     <= in_valid;
            t_valid_reg     <= a_valid_reg;
            h_valid_reg     <= t_valid_reg;
            q_valid_reg     <= h_valid_reg;
            sq_valid_reg[0] <= q_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_side_reg  <= {in_data[4*VW+RAW_W], (all_in == '0), neg, in_data[4*VW +: RAW_W]};
        a_m_reg     <= mag;
        a_all_reg   <= all_in;
        t_side_reg  <= a_side_reg;
        t_m_reg     <= a_m_reg;
        t_top_reg   <= top;
        h_side_reg  <= t_side_reg;
        h_m_reg     <= shifted;
        q_side_reg  <= h_side_reg;
        q_m_reg     <= h_m_reg;
        for (int i = 0; i < 4; i++)
        begin
            q_sq_reg[i] <= h_m_reg[i] * h_m_reg[i];
        end
        sq_side_reg[0] <= q_side_reg;
        sq_m_reg[0]    <= q_m_reg;
        sq_n_reg[0]    <= SQW'(q_sq_reg[0]) + SQW'(q_sq_reg[1])
                        + SQW'(q_sq_reg[2]) + SQW'(q_sq_reg[3]);
        sq_r_reg[0]    <= '0;
    end

    for (genvar k = 1; k <= SQ_STEPS; k++)
    begin : g_sqrt
        localparam logic [SQW-1:0] BIT = SQW'(1) << (2 * (SQ_STEPS - k));
        logic [SQW-1:0] trial;
        logic [SQW-1:0] n_next;
        logic [SQW-1:0] r_next;

        always_comb
        begin
            trial = sq_r_reg[k-1] + BIT;
            if (sq_n_reg[k-1] >= trial)
            begin
                n_next = sq_n_reg[k-1] - trial;
                r_next = (sq_r_reg[k-1] >> 1) + BIT;
            end
            else
            begin
                n_next = sq_n_reg[k-1];
                r_next = sq_r_reg[k-1] >> 1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sq_valid_reg[k] <= 1'b0;
            end
            else
            begin
                sq_valid_reg[k] <= sq_valid_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            sq_n_reg[k]    <= n_next;
            sq_r_reg[k]    <= r_next;
            sq_side_reg[k] <= sq_side_reg[k-1];
            sq_m_reg[k]    <= sq_m_reg[k-1];
        end
    end

    assign len = sq_r_reg[SQ_STEPS][LW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_valid_reg[0] <= 1'b0;
        end
        else
        begin
            dv_valid_reg[0] <= sq_valid_reg[SQ_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        dv_side_reg[0] <= sq_side_reg[SQ_STEPS];
        dv_len_reg[0]  <= len;
        for (int i = 0; i < 4; i++)
        begin
            dv_rem_reg[0][i] <= (DW'(sq_m_reg[SQ_STEPS][i]) << F) + DW'(len >> 1);
            dv_q_reg[0][i]   <= '0;
        end
    end

    for (genvar j = 1; j <= QW; j++)
    begin : g_div
        localparam int B = QW - j;
        logic [DW-1:0] d;
        logic [DW-1:0] rem_next [4];
        logic [QW-1:0] q_next [4];

        always_comb
        begin
            d = DW'(dv_len_reg[j-1]) << B;
            for (int i = 0; i < 4; i++)
            begin
                if (dv_rem_reg[j-1][i] >= d)
                begin
                    rem_next[i] = dv_rem_reg[j-1][i] - d;
                    q_next[i]   = dv_q_reg[j-1][i] | (QW'(1) << B);
                end
                else
                begin
                    rem_next[i] = dv_rem_reg[j-1][i];
                    q_next[i]   = dv_q_reg[j-1][i];
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_valid_reg[j] <= 1'b0;
            end
            else
            begin
                dv_valid_reg[j] <= dv_valid_reg[j-1];
            end
        end

        always_ff @(posedge clk)
        begin
            dv_side_reg[j] <= dv_side_reg[j-1];
            dv_len_reg[j]  <= dv_len_reg[j-1];
            dv_rem_reg[j]  <= rem_next;
            dv_q_reg[j]    <= q_next;
        end
    end

    assign fin_side = dv_side_reg[QW];

    always_comb
    begin
        logic signed [W-1:0] m;
        zero_next = 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            m = signed'(W'(dv_q_reg[QW][i]));
            if (fin_side[SIDE_W-1])
            begin
                res_next[i] = signed'(fin_side[i*W +: W]);
            end
            else if (fin_side[SIDE_W-2])
            begin
                res_next[i] = '0;
                zero_next   = 1'b1;
            end
            else if (fin_side[RAW_W+i])
            begin
                res_next[i] = -m;
            end
            else
            begin
                res_next[i] = m;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= dv_valid_reg[QW];
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg  <= res_next;
        out_zero_reg <= zero_next;
    end

    assign done        = out_valid_reg;
    assign res_x       = out_res_reg[0];
    assign res_y       = out_res_reg[1];
    assign res_z       = out_res_reg[2];
    assign res_w       = out_res_reg[3];
    assign zero_length = out_zero_reg;

endmodule

### hdl/quaternion_product_normalize.sv
// Quaternion unit: Hamilton product, normalize, normalized conjugate and conjugate.
// The back end holds a 31-step square root and a COMP_WIDTH - 1 step divider pipeline.
// Throughput: one transaction per cycle; busy rises when queue and front stages hold DEPTH.
// Reset: rst_n clears all valid state asynchronously; results are never held off.
// Depends on qpn_pkg, qpn_front, qpn_queue and qpn_back.
module quaternion_product_normalize #(
    parameter int COMP_WIDTH = qpn_pkg::COMP_WIDTH,
    parameter int DEPTH      = qpn_pkg::QUEUE_DEPTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    req_type,
    input  logic signed [COMP_WIDTH-1:0]  a_x,
    input  logic signed [COMP_WIDTH-1:0]  a_y,
    input  logic signed [COMP_WIDTH-1:0]  a_z,
    input  logic signed [COMP_WIDTH-1:0]  a_w,
    input  logic signed [COMP_WIDTH-1:0]  b_x,
    input  logic signed [COMP_WIDTH-1:0]  b_y,
    input  logic signed [COMP_WIDTH-1:0]  b_z,
    input  logic signed [COMP_WIDTH-1:0]  b_w,
    output logic                          done,
    output logic signed [COMP_WIDTH-1:0]  res_x,
    output logic signed [COMP_WIDTH-1:0]  res_y,
    output logic signed [COMP_WIDTH-1:0]  res_z,
    output logic signed [COMP_WIDTH-1:0]  res_w,
    output logic                          zero_length
);

    localparam int DATA_W  = 12 * COMP_WIDTH + 9;
    localparam int CW      = $clog2(DEPTH + 1);
    localparam int LATENCY = COMP_WIDTH + 41;

    logic                 accept;
    logic                 push;
    logic [DATA_W-1:0]    push_data;
    qpn_pkg::front_stat_t fstat;
    logic [CW-1:0]        level;
    logic                 q_valid;
    logic [DATA_W-1:0]    q_data;
    logic [CW+1:0]        occupancy;

    assign occupancy = (CW+2)'(level) + (CW+2)'(fstat.s1_valid) + (CW+2)'(fstat.s2_valid);
    assign busy      = (occupancy >= (CW+2)'(DEPTH));
    assign accept    = start && !busy;

    qpn_front #(
        .COMP_WIDTH (COMP_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .req_type  (req_type),
        .a_x       (a_x),
        .a_y       (a_y),
        .a_z       (a_z),
        .a_w       (a_w),
        .b_x       (b_x),
        .b_y       (b_y),
        .b_z       (b_z),
        .b_w       (b_w),
        .push      (push),
        .push_data (push_data),
        .stat      (fstat)
    );

    qpn_queue #(
        .DATA_W (DATA_W),
        .DEPTH  (DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .level     (level),
        .out_valid (q_valid),
        .out_data  (q_data)
    );

    qpn_back #(
        .COMP_WIDTH (COMP_WIDTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (q_valid),
        .in_data     (q_data),
        .done        (done),
        .res_x       (res_x),
        .res_y       (res_y),
        .res_z       (res_z),
        .res_w       (res_w),
        .zero_length (zero_length)
    );

    // Every accepted transaction produces exactly one result on done.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##LATENCY done)
        else $error("accepted transaction produced no result");

    a_result_has_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, LATENCY))
        else $error("result without an accepted transaction");

endmodule

### dv/testbench.sv
// Self-checking testbench for the quaternion product and normalize unit.
// Drives directed and random requests through the start/busy handshake and checks done results.
// Depends on qpn_pkg and quaternion_product_normalize.
`timescale 1ns / 1ps

module testbench;

    localparam int W = qpn_pkg::COMP_WIDTH;
    localparam int FRAC = W - 2;
    localparam int LATENCY = W + 41;
    localparam int RANDOM_COUNT = 1700;
    localparam longint CYCLE_LIMIT = 400000;

    typedef logic signed [W-1:0] comp_t;

    typedef struct {
        logic [1:0] op;
        comp_t a [4];
        comp_t b [4];
    } request_t;

    typedef struct {
        comp_t q [4];
        logic zero;
    } quat_result_t;

    typedef struct {
        request_t req;
        logic known;
        quat_result_t res;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [1:0] req_type = qpn_pkg::REQ_CONJ;
    comp_t a_x = '0, a_y = '0, a_z = '0, a_w = '0;
    comp_t b_x = '0, b_y = '0, b_z = '0, b_w = '0;
    logic done;
    comp_t res_x, res_y, res_z, res_w;
    logic zero_length;

    quat_result_t pending_results [$];
    int mismatches = 0;
    int results_seen = 0;
    int op_count [4] = '{0, 0, 0, 0};
    int zero_count = 0;
    longint cycles = 0;

    quaternion_product_normalize uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .req_type(req_type),
        .a_x(a_x), .a_y(a_y), .a_z(a_z), .a_w(a_w),
        .b_x(b_x), .b_y(b_y), .b_z(b_z), .b_w(b_w),
        .done(done), .res_x(res_x), .res_y(res_y), .res_z(res_z), .res_w(res_w),
        .zero_length(zero_length)
    );

    always #4 clk = ~clk;

    function automatic comp_t saturate(longint v);
        longint hi;
        hi = (longint'(1) << (W - 1)) - 1;
        if (v > hi)
            return comp_t'(hi);
        if (v < -hi - 1)
            return comp_t'(-hi - 1);
        return comp_t'(v);
    endfunction

    function automatic longint unsigned floor_sqrt(longint unsigned n);
        longint unsigned r, bitv;
        r = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (n >= r + bitv)
            begin
                n = n - (r + bitv);
                r = (r >> 1) + bitv;
            end
            else
                r = r >> 1;
            bitv = bitv >> 2;
        end
        return r;
    endfunction

    function automatic quat_result_t unit_quat(longint v [4]);
        quat_result_t o;
        longint unsigned m [4];
        longint unsigned all_bits, sum, len, r;
        logic neg [4];
        int top;
        all_bits = 0;
        sum = 0;
        top = 0;
        for (int i = 0; i < 4; i++)
        begin
            neg[i] = v[i] < 0;
            m[i] = neg[i] ? longint'(-v[i]) : longint'(v[i]);
            all_bits |= m[i];
        end
        if (all_bits == 0)
        begin
            for (int i = 0; i < 4; i++)
                o.q[i] = '0;
            o.zero = 1'b1;
            return o;
        end
        while (top < 63 && (all_bits >> (top + 1)) != 0)
            top++;
        for (int i = 0; i < 4; i++)
        begin
            if (top > qpn_pkg::TOP_BIT)
                m[i] = m[i] >> (top - qpn_pkg::TOP_BIT);
            else
                m[i] = m[i] << (qpn_pkg::TOP_BIT - top);
            sum += m[i] * m[i];
        end
        len = floor_sqrt(sum);
        for (int i = 0; i < 4; i++)
        begin
            r = ((m[i] << FRAC) + (len >> 1)) / len;
            o.q[i] = saturate(neg[i] ? -longint'(r) : longint'(r));
        end
        o.zero = 1'b0;
        return o;
    endfunction

    function automatic quat_result_t predict_quat(request_t rq);
        longint a [4], b [4], v [4];
        quat_result_t o;
        for (int i = 0; i < 4; i++)
        begin
            a[i] = rq.a[i];
            b[i] = rq.b[i];
        end
        case (rq.op)
            qpn_pkg::REQ_PRODUCT:
            begin
                v[0] = a[1]*b[2] - a[2]*b[1] + a[0]*b[3] + a[3]*b[0];
                v[1] = -a[0]*b[2] + a[2]*b[0] + a[1]*b[3] + a[3]*b[1];
                v[2] = a[0]*b[1] - a[1]*b[0] + a[2]*b[3] + a[3]*b[2];
                v[3] = a[3]*b[3] - a[0]*b[0] - a[1]*b[1] - a[2]*b[2];
                o = unit_quat(v);
            end
            qpn_pkg::REQ_NORM:
            begin
                v = a;
                o = unit_quat(v);
            end
            qpn_pkg::REQ_NORM_CONJ:
            begin
                v[0] = -a[0]; v[1] = -a[1]; v[2] = -a[2]; v[3] = a[3];
                o = unit_quat(v);
            end
            default:
            begin
                o.q[0] = saturate(-a[0]);
                o.q[1] = saturate(-a[1]);
                o.q[2] = saturate(-a[2]);
                o.q[3] = rq.a[3];
                o.zero = 1'b0;
            end
        endcase
        return o;
    endfunction

    function automatic comp_t rand_comp();
        case ($urandom_range(0, 9))
            0: return comp_t'(16'sh8000);
            1: return comp_t'(16'sh7fff);
            2: return '0;
            3: return comp_t'($urandom_range(0, 15)) - 8;
            4, 5: return comp_t'($urandom_range(0, 2 ** FRAC)) - comp_t'(2 ** (FRAC - 1));
            default: return comp_t'($urandom);
        endcase
    endfunction

    function automatic request_t rand_request();
        request_t rq;
        rq.op = 2'($urandom_range(0, 3));
        for (int i = 0; i < 4; i++)
        begin
            rq.a[i] = rand_comp();
            rq.b[i] = rand_comp();
        end
        if ($urandom_range(0, 15) == 0)
            for (int i = 0; i < 4; i++)
                rq.a[i] = '0;
        return rq;
    endfunction

    function automatic request_t make_req(logic [1:0] op, comp_t ax, comp_t ay, comp_t az,
                                          comp_t aw, comp_t bx, comp_t by, comp_t bz,
                                          comp_t bw);
        request_t rq;
        rq.op = op;
        rq.a = '{ax, ay, az, aw};
        rq.b = '{bx, by, bz, bw};
        return rq;
    endfunction

    task automatic send_request(request_t rq);
        @(negedge clk);
        start <= 1'b1;
        req_type <= rq.op;
        a_x <= rq.a[0]; a_y <= rq.a[1]; a_z <= rq.a[2]; a_w <= rq.a[3];
        b_x <= rq.b[0]; b_y <= rq.b[1]; b_z <= rq.b[2]; b_w <= rq.b[3];
        do
            @(posedge clk);
        while (busy);
        op_count[rq.op]++;
    endtask

    task automatic sender_gap();
        int n;
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 60) :
            ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
        if (n > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (n - 1) @(negedge clk);
        end
    endtask

    task automatic drop_start();
        @(negedge clk);
        start <= 1'b0;
    endtask

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycles);
            $display("Mismatches found");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        quat_result_t got, want;
        if (rst_n && done)
        begin
            got.q = '{res_x, res_y, res_z, res_w};
            got.zero = zero_length;
            results_seen++;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result transaction at cycle %0d", cycles);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.zero)
                    zero_count++;
                if (got.q != want.q || got.zero !== want.zero)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Result %0d: expected %0d %0d %0d %0d z%0b, got %0d %0d %0d %0d z%0b",
                                 results_seen, want.q[0], want.q[1], want.q[2], want.q[3],
                                 want.zero, got.q[0], got.q[1], got.q[2], got.q[3], got.zero);
                end
            end
        end
    end

    initial
    begin
        stim_row_t rows [$];
        stim_row_t row;
        request_t rq;
        comp_t mx, mn, one;
        int waited;
        mx = comp_t'(16'sh7fff);
        mn = comp_t'(16'sh8000);
        one = comp_t'(2 ** FRAC);

        row.known = 1'b1;
        row.req = make_req(qpn_pkg::REQ_NORM, 0, 0, 0, 0, 1, 2, 3, 4);
        row.res.q = '{0, 0, 0, 0}; row.res.zero = 1'b1; rows.push_back(row);
        row.req = make_req(qpn_pkg::REQ_NORM_CONJ, 0, 0, 0, 0, mx, mx, mx, mx);
        rows.push_back(row);
        row.req = make_req(qpn_pkg::REQ_PRODUCT, 0, 0, 0, 0, mx, mn, 5, 7);
        rows.push_back(row);
        row.req = make_req(qpn_pkg::REQ_PRODUCT, 1, 2, 3, 4, 0, 0, 0, 0);
        rows.push_back(row);
        row.req = make_req(qpn_pkg::REQ_NORM, 0, 0, 0, one, 0, 0, 0, 0);
        row.res.q = '{0, 0, 0, one}; row.res.zero = 1'b0; rows.push_back(row);
        row.req = make_req(qpn_pkg::REQ_NORM, 0, 0, 0, 1, 0, 0, 0, 0);
        rows.push_back(row);
        row.req = make_req(qpn_pkg::REQ_NORM, 0, 0, 0, mn, 0, 0, 0, 0);
        row.res.q = '{0, 0, 0, -one}; rows.push_back(row);
        row.req = make_req(qpn_pkg::REQ_NORM, mx, 0, 0, 0, 0, 0, 0, 0);
        row.res.q = '{one, 0, 0, 0}; rows.push_back(row);
        row.req = make_req(qpn_pkg::REQ_CONJ, mn, mx, 0, mn, 0, 0, 0, 0);
        row.res.q = '{mx, mn + 1, 0, mn}; rows.push_back(row);
        row.req = make_req(qpn_pkg::REQ_CONJ, 1, -1, mn, mx, mx, mx, mx, mx);
        row.res.q = '{-1, 1, mx, mx}; rows.push_back(row);
        row.req = make_req(qpn_pkg::REQ_CONJ, 0, 0, 0, 0, 0, 0, 0, 0);
        row.res.q = '{0, 0, 0, 0}; rows.push_back(row);
        row.req = make_req(qpn_pkg::REQ_PRODUCT, 0, 0, 0, one, 0, 0, 0, one);
        row.res.q = '{0, 0, 0, one}; rows.push_back(row);
        row.known = 1'b0;
        rows.push_back('{make_req(qpn_pkg::REQ_NORM, mx, mx, mx, mx, 0, 0, 0, 0),
                         1'b0, row.res});
        rows.push_back('{make_req(qpn_pkg::REQ_NORM, mn, mn, mn, mn, 0, 0, 0, 0),
                         1'b0, row.res});
        rows.push_back('{make_req(qpn_pkg::REQ_NORM_CONJ, mn, mx, -1, 1, 0, 0, 0, 0),
                         1'b0, row.res});
        rows.push_back('{make_req(qpn_pkg::REQ_PRODUCT, mn, mn, mn, mn, mn, mn, mn, mn),
                         1'b0, row.res});
        rows.push_back('{make_req(qpn_pkg::REQ_PRODUCT, mx, mx, mx, mx, mn, mn, mn, mn),
                         1'b0, row.res});
        rows.push_back('{make_req(qpn_pkg::REQ_PRODUCT, mx, mn, mx, mn, mn, mx, mn, mx),
                         1'b0, row.res});
        rows.push_back('{make_req(qpn_pkg::REQ_PRODUCT, 1, 0, 0, 0, 0, 1, 0, 0),
                         1'b0, row.res});
        rows.push_back('{make_req(qpn_pkg::REQ_PRODUCT, 1, 1, 1, 1, 1, -1, 1, -1),
                         1'b0, row.res});
        rows.push_back('{make_req(qpn_pkg::REQ_NORM_CONJ, 3, 4, 0, 0, 0, 0, 0, 0),
                         1'b0, row.res});

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (rows[i])
        begin
            pending_results.push_back(rows[i].known ? rows[i].res : predict_quat(rows[i].req));
            send_request(rows[i].req);
            if (rows[i].known && rows[i].res != predict_quat(rows[i].req))
                $display("Directed row %0d disagrees with predictor", i);
            if (i % 5 == 4)
                sender_gap();
        end
        drop_start();

        for (int n = 0; n < RANDOM_COUNT; n++)
        begin
            if (n == RANDOM_COUNT / 2)
            begin
                drop_start();
                while (pending_results.size() != 0)
                    @(posedge clk);
            end
            rq = rand_request();
            pending_results.push_back(predict_quat(rq));
            send_request(rq);
            if (n % 200 >= 100)
                sender_gap();
        end
        drop_start();

        waited = 0;
        while (pending_results.size() != 0 && waited < 20 * LATENCY + 1000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (LATENCY + 10) @(posedge clk);

        if (pending_results.size() != 0)
        begin
            mismatches++;
            $display("%0d expected results never arrived", pending_results.size());
        end
        $display("Covered %0d products, %0d normalizations, %0d normalized and %0d plain conjugates;",
                 op_count[0], op_count[1], op_count[2], op_count[3]);
        $display("%0d results checked, %0d with zero length, %0d mismatches.",
                 results_seen, zero_count, mismatches);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
